// ===== rtl/cpmv_pkg.sv =====
package cpmv_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PC_W    = 5;
  localparam int unsigned PCNT_W  = 5;
  localparam int unsigned VOL_W   = 7;
  localparam int unsigned LASTV_W = 8;
  localparam int unsigned ADDR_W  = 4;

  localparam logic [7:0] MIDI_SYNC     = 8'h88;
  localparam logic [7:0] MIDI_CC       = 8'hB0;
  localparam logic [7:0] MIDI_CTRL_VOL = 8'h07;

  localparam logic [1:0] REG_TICKS_PER_US = 2'd0;
  localparam logic [1:0] REG_VOLUME_SCALE = 2'd1;
  localparam logic [1:0] REG_VOLUME_MAX   = 2'd2;

  typedef enum logic [3:0] {
    ACT_NOP      = 4'd0,
    ACT_ACCEPT   = 4'd1,
    ACT_DIV_PER  = 4'd2,
    ACT_ADD_SUM  = 4'd3,
    ACT_AVG_MUL  = 4'd4,
    ACT_DIV_VOL  = 4'd5,
    ACT_CLAMP    = 4'd6,
    ACT_VMAX     = 4'd7,
    ACT_SET_LAST = 4'd8,
    ACT_EMIT     = 4'd9,
    ACT_VOL_ZERO = 4'd10
  } act_e;

  typedef enum logic [3:0] {
    C_NEVER       = 4'd0,
    C_ALWAYS      = 4'd1,
    C_NOT_FIRE    = 4'd2,
    C_MODE        = 4'd3,
    C_DIV_BUSY    = 4'd4,
    C_PCNT_LT_WIN = 4'd5,
    C_AVG_ZERO    = 4'd6,
    C_VOL_EQ_LAST = 4'd7,
    C_OUT_FULL    = 4'd8,
    C_LAST_ZERO   = 4'd9
  } cond_e;

  typedef enum logic [2:0] {
    BYTE_SYNC0 = 3'd0,
    BYTE_SYNC1 = 3'd1,
    BYTE_CC    = 3'd2,
    BYTE_CTRL  = 3'd3,
    BYTE_VALUE = 3'd4
  } byte_sel_e;

  typedef struct packed {
    act_e              act;
    cond_e             cond;
    logic [PC_W-1:0]   target;
    byte_sel_e         sel;
  } uword_t;

  typedef struct packed {
    act_e      act;
    byte_sel_e sel;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic mode;
    logic div_busy;
    logic pcnt_lt_win;
    logic avg_zero;
    logic vol_eq_last;
    logic out_full;
    logic last_zero;
  } status_t;

endpackage

// ===== rtl/cpmv_div.sv =====
module cpmv_div #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             busy_o,
  output logic [WIDTH-1:0] quot_o
);

  localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] rem_q, quo_q, dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [WIDTH:0]   trial;

  assign trial = {rem_q, quo_q[WIDTH-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(WIDTH - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[WIDTH]) begin
        rem_q <= trial[WIDTH-1:0];
        quo_q <= {quo_q[WIDTH-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[WIDTH-2:0], quo_q[WIDTH-1]};
        quo_q <= {quo_q[WIDTH-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/cpmv_ctrl.sv =====
module cpmv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpmv_pkg::status_t status_i,
  output cpmv_pkg::ctrl_t   ctrl_o
);

  localparam int unsigned PC_W = cpmv_pkg::PC_W;

  function automatic cpmv_pkg::uword_t rom(input logic [PC_W-1:0] pc);
    cpmv_pkg::uword_t w;
    w = '{act: cpmv_pkg::ACT_NOP, cond: cpmv_pkg::C_ALWAYS, target: '0,
          sel: cpmv_pkg::BYTE_SYNC0};
    case (pc)
      5'd0:  begin w.act = cpmv_pkg::ACT_ACCEPT; w.cond = cpmv_pkg::C_NOT_FIRE; end
      5'd1:  begin w.cond = cpmv_pkg::C_MODE; w.target = 5'd19; end
      5'd2:  begin w.act = cpmv_pkg::ACT_DIV_PER; w.cond = cpmv_pkg::C_NEVER; end
      5'd3:  begin w.cond = cpmv_pkg::C_DIV_BUSY; w.target = 5'd3; end
      5'd4:  begin w.act = cpmv_pkg::ACT_ADD_SUM; w.cond = cpmv_pkg::C_NEVER; end
      5'd5:  begin w.cond = cpmv_pkg::C_PCNT_LT_WIN; end
      5'd6:  begin w.act = cpmv_pkg::ACT_AVG_MUL; w.cond = cpmv_pkg::C_NEVER; end
      5'd7:  begin w.cond = cpmv_pkg::C_AVG_ZERO; w.target = 5'd11; end
      5'd8:  begin w.act = cpmv_pkg::ACT_DIV_VOL; w.cond = cpmv_pkg::C_NEVER; end
      5'd9:  begin w.cond = cpmv_pkg::C_DIV_BUSY; w.target = 5'd9; end
      5'd10: begin w.act = cpmv_pkg::ACT_CLAMP; w.target = 5'd12; end
      5'd11: begin w.act = cpmv_pkg::ACT_VMAX; w.cond = cpmv_pkg::C_NEVER; end
      5'd12: begin w.act = cpmv_pkg::ACT_SET_LAST; w.cond = cpmv_pkg::C_VOL_EQ_LAST; end
      5'd13: begin
        w.act = cpmv_pkg::ACT_EMIT; w.cond = cpmv_pkg::C_OUT_FULL;
        w.target = 5'd13; w.sel = cpmv_pkg::BYTE_SYNC0;
      end
      5'd14: begin
        w.act = cpmv_pkg::ACT_EMIT; w.cond = cpmv_pkg::C_OUT_FULL;
        w.target = 5'd14; w.sel = cpmv_pkg::BYTE_SYNC1;
      end
      5'd15: begin
        w.act = cpmv_pkg::ACT_EMIT; w.cond = cpmv_pkg::C_OUT_FULL;
        w.target = 5'd15; w.sel = cpmv_pkg::BYTE_CC;
      end
      5'd16: begin
        w.act = cpmv_pkg::ACT_EMIT; w.cond = cpmv_pkg::C_OUT_FULL;
        w.target = 5'd16; w.sel = cpmv_pkg::BYTE_CTRL;
      end
      5'd17: begin
        w.act = cpmv_pkg::ACT_EMIT; w.cond = cpmv_pkg::C_OUT_FULL;
        w.target = 5'd17; w.sel = cpmv_pkg::BYTE_VALUE;
      end
      5'd18: begin w.cond = cpmv_pkg::C_ALWAYS; end
      5'd19: begin w.cond = cpmv_pkg::C_LAST_ZERO; end
      5'd20: begin w.act = cpmv_pkg::ACT_VOL_ZERO; w.target = 5'd13; end
      default: begin w.cond = cpmv_pkg::C_ALWAYS; end
    endcase
    return w;
  endfunction

  logic [PC_W-1:0]  pc_q, pc_d;
  cpmv_pkg::uword_t word;
  logic             take;

  assign word = rom(pc_q);

  always_comb begin
    case (word.cond)
      cpmv_pkg::C_NEVER:       take = 1'b0;
      cpmv_pkg::C_ALWAYS:      take = 1'b1;
      cpmv_pkg::C_NOT_FIRE:    take = !status_i.in_fire;
      cpmv_pkg::C_MODE:        take = status_i.mode;
      cpmv_pkg::C_DIV_BUSY:    take = status_i.div_busy;
      cpmv_pkg::C_PCNT_LT_WIN: take = status_i.pcnt_lt_win;
      cpmv_pkg::C_AVG_ZERO:    take = status_i.avg_zero;
      cpmv_pkg::C_VOL_EQ_LAST: take = status_i.vol_eq_last;
      cpmv_pkg::C_OUT_FULL:    take = status_i.out_full;
      cpmv_pkg::C_LAST_ZERO:   take = status_i.last_zero;
      default:                 take = 1'b1;
    endcase
    pc_d = take ? word.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = '{act: word.act, sel: word.sel};

endmodule

// ===== rtl/capture_period_to_midi_volume.sv =====
// Channel      Direction  Handshake                Payload
// s_axis       in         tvalid/tready            tdata: capture_count; tuser: mode
// m_axis       out        tvalid/tready            tdata: midi_byte; tlast: last_byte
// apb          in         psel/penable/pready      ticks_per_us, volume_scale, volume_max
//
// An edge word that does not close a window runs the 32-step serial divider for
// its period. One that closes a window runs it again for the volume, after the
// average, which is a multiply by a constant reciprocal; a zero average skips that
// division. A message follows when the volume changes, and a timeout may send one
// too. Input is taken only at the fetch step; a stalled output holds the emit
// step. Reset is asynchronous and active low and restores the register defaults.
module capture_period_to_midi_volume #(
  parameter int unsigned WINDOW = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] capture_count
  input  logic        s_axis_tuser_i,   // [0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] midi_byte
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DW  = cpmv_pkg::DATA_W;
  localparam int unsigned PW  = cpmv_pkg::PCNT_W;
  localparam int unsigned VW  = cpmv_pkg::VOL_W;
  localparam int unsigned LW  = cpmv_pkg::LASTV_W;

  // The average is floor(sum * AVG_MUL / 2^(DW + AVG_SH)), exact for every sum.
  localparam int unsigned AVG_SH = $clog2(WINDOW);
  localparam logic [DW:0] AVG_MUL =
    (DW+1)'(((64'd1 << (DW + AVG_SH)) / 64'(WINDOW)) + 64'd1);

  logic [7:0]    tpu_q;
  logic [23:0]   scale_q;
  logic [VW-1:0] vmax_q;

  logic [DW-1:0] count_q, prev_q, sum_q, avg_q;
  logic          mode_q;
  logic [PW-1:0] pcnt_q;
  logic [VW-1:0] vol_q;
  logic [LW-1:0] last_q;

  logic          m_valid_q, m_last_q;
  logic [7:0]    m_data_q;

  cpmv_pkg::ctrl_t   ctrl;
  cpmv_pkg::status_t status;

  logic          div_start, div_busy;
  logic [DW-1:0] dividend, divisor, quot;
  logic [2*DW:0] avg_prod;
  logic          in_fire, out_full, wr_en, emit;
  logic [7:0]    emit_byte;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_full = m_valid_q && !m_axis_tready_i;
  assign emit     = (ctrl.act == cpmv_pkg::ACT_EMIT) && !out_full;

  assign s_axis_tready_o = (ctrl.act == cpmv_pkg::ACT_ACCEPT);

  always_comb begin
    case (paddr[3:2])
      cpmv_pkg::REG_TICKS_PER_US: prdata = {24'd0, tpu_q};
      cpmv_pkg::REG_VOLUME_SCALE: prdata = {8'd0, scale_q};
      cpmv_pkg::REG_VOLUME_MAX:   prdata = {25'd0, vmax_q};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q   <= 8'd80;
      scale_q <= 24'd300000;
      vmax_q  <= 7'd125;
    end else if (wr_en) begin
      case (paddr[3:2])
        cpmv_pkg::REG_TICKS_PER_US: tpu_q   <= pwdata[7:0];
        cpmv_pkg::REG_VOLUME_SCALE: scale_q <= pwdata[23:0];
        cpmv_pkg::REG_VOLUME_MAX:   vmax_q  <= pwdata[VW-1:0];
        default: ;
      endcase
    end
  end

  assign avg_prod = {{(DW+1){1'b0}}, sum_q} * {{DW{1'b0}}, AVG_MUL};

  always_comb begin
    div_start = 1'b0;
    dividend  = count_q - prev_q;
    divisor   = (tpu_q == 8'd0) ? DW'(1) : {24'd0, tpu_q};
    case (ctrl.act)
      cpmv_pkg::ACT_DIV_PER: div_start = 1'b1;
      cpmv_pkg::ACT_DIV_VOL: begin
        div_start = 1'b1;
        dividend  = {8'd0, scale_q};
        divisor   = avg_q;
      end
      default: ;
    endcase
  end

  cpmv_div #(.WIDTH(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_comb begin
    status.in_fire     = in_fire;
    status.mode        = mode_q;
    status.div_busy    = div_busy;
    status.pcnt_lt_win = pcnt_q < PW'(WINDOW);
    status.avg_zero    = (avg_q == '0);
    status.vol_eq_last = ({1'b0, vol_q} == last_q);
    status.out_full    = out_full;
    status.last_zero   = (last_q == '0);
  end

  cpmv_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      count_q <= s_axis_tdata_i;
      mode_q  <= s_axis_tuser_i;
    end
    case (ctrl.act)
      cpmv_pkg::ACT_AVG_MUL:  avg_q <= DW'(avg_prod >> (DW + AVG_SH));
      cpmv_pkg::ACT_CLAMP:
        vol_q <= (quot > {25'd0, vmax_q}) ? vmax_q : quot[VW-1:0];
      cpmv_pkg::ACT_VMAX:     vol_q <= vmax_q;
      cpmv_pkg::ACT_VOL_ZERO: vol_q <= '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      sum_q  <= '0;
      pcnt_q <= '0;
      last_q <= LW'(1);
    end else begin
      case (ctrl.act)
        cpmv_pkg::ACT_DIV_PER: prev_q <= count_q;
        cpmv_pkg::ACT_ADD_SUM: begin
          sum_q  <= sum_q + quot;
          pcnt_q <= pcnt_q + 1'b1;
        end
        cpmv_pkg::ACT_AVG_MUL: begin
          sum_q  <= '0;
          pcnt_q <= '0;
        end
        cpmv_pkg::ACT_SET_LAST: last_q <= {1'b0, vol_q};
        cpmv_pkg::ACT_VOL_ZERO: last_q <= '0;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ctrl.sel)
      cpmv_pkg::BYTE_SYNC0: emit_byte = cpmv_pkg::MIDI_SYNC;
      cpmv_pkg::BYTE_SYNC1: emit_byte = cpmv_pkg::MIDI_SYNC;
      cpmv_pkg::BYTE_CC:    emit_byte = cpmv_pkg::MIDI_CC;
      cpmv_pkg::BYTE_CTRL:  emit_byte = cpmv_pkg::MIDI_CTRL_VOL;
      cpmv_pkg::BYTE_VALUE: emit_byte = {1'b0, vol_q};
      default:              emit_byte = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= emit_byte;
      m_last_q <= (ctrl.sel == cpmv_pkg::BYTE_VALUE);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule
